### rtl/core/lbrl_pkg.sv
// shared types and codes of the leaky bucket rate limiter
`default_nettype none
package lbrl_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [1:0]        t_op;
    typedef logic [1:0]        t_cfg_idx;

    // item operation codes
    localparam t_op OP_BORROW = 2'd0;
    localparam t_op OP_LEAK   = 2'd1;
    localparam t_op OP_UPDATE = 2'd2;
    localparam t_op OP_NONE   = 2'd3;

    // configuration register indexes
    localparam t_cfg_idx CFG_ENABLED   = 2'd0;
    localparam t_cfg_idx CFG_MAX_RATE  = 2'd1;
    localparam t_cfg_idx CFG_MAX_DELAY = 2'd2;
    localparam t_cfg_idx CFG_UNUSED    = 2'd3;

endpackage
`default_nettype wire

### rtl/core/lbrl_mul.sv
// bit-serial shift-add fixed point multiplier with saturation
`default_nettype none
module lbrl_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  lbrl_pkg::t_word i_a,
    input  lbrl_pkg::t_word i_b,
    output logic           o_busy,
    output lbrl_pkg::t_word o_result
);
    import lbrl_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]    r_cnt;
    logic [2*WORD_W-1:0] r_acc;
    t_word               r_mcand;
    logic [WORD_W:0]     w_sum;
    logic                w_sat;

    assign o_busy = (r_cnt != '0);

    // one multiplier bit per cycle, partial sum shifts right
    assign w_sum = {1'b0, r_acc[2*WORD_W-1:WORD_W]}
                 + (r_acc[0] ? {1'b0, r_mcand} : {(WORD_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(WORD_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= {{WORD_W{1'b0}}, i_b};
            r_mcand <= i_a;
        end else if (o_busy) begin
            r_acc <= {w_sum, r_acc[WORD_W-1:1]};
        end
    end

    // drop the fraction, clamp at full scale
    assign w_sat    = |r_acc[2*WORD_W-1:WORD_W+FRAC_BITS];
    assign o_result = w_sat ? {WORD_W{1'b1}} : r_acc[WORD_W+FRAC_BITS-1:FRAC_BITS];

endmodule
`default_nettype wire

### rtl/core/lbrl_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module lbrl_div #(
    parameter int DW = 33
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  wire  [DW-1:0]   i_dividend,
    input  lbrl_pkg::t_word i_divisor,
    output logic            o_busy,
    output logic [DW-1:0]   o_quot
);
    import lbrl_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_dq;
    t_word            r_rem;
    t_word            r_dvs;
    logic [WORD_W:0]  w_trial;
    logic [WORD_W+1:0] w_diff;
    logic             w_qbit;

    assign o_busy = (r_cnt != '0);

    // bring down the next dividend bit and try a subtract
    assign w_trial = {r_rem, r_dq[DW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};
    assign w_qbit  = !w_diff[WORD_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (o_busy) begin
            r_dq  <= {r_dq[DW-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[WORD_W-1:0] : w_trial[WORD_W-1:0];
        end
    end

    assign o_quot = r_dq;

endmodule
`default_nettype wire

### rtl/core/leaky_bucket_rate_limiter_core.sv
// top level of the leaky bucket rate limiter
`default_nettype none
// steps: borrow and unused op pass from the apply step through the finish step to the
// output register; leak tick first waits in the run step for the bit-serial multiplier and divider,
// update limit for the bit-serial multiplier only (fixed point is Q16.16 at FRAC_BITS 16)
// throughput: one item at a time; the next input transaction may be taken while
// a result still waits in the output register
// reset clears sequencer, configuration, bucket state and output valid; a configuration
// write that hits a register keeps both channels stalled while the ceiling is recomputed
module leaky_bucket_rate_limiter_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // item input channel
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  lbrl_pkg::t_op        i_op,
    input  lbrl_pkg::t_word      i_interval,
    input  lbrl_pkg::t_word      i_limit,
    // result output channel
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic                 o_below_limit,
    output logic                 o_granted,
    output logic                 o_slot_freed,
    output lbrl_pkg::t_word      o_next_interval,
    output lbrl_pkg::t_word      o_level,
    // configuration write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  lbrl_pkg::t_cfg_idx   i_cfg_index,
    input  lbrl_pkg::t_word      i_cfg_data
);
    import lbrl_pkg::*;

    // fixed point constants, all settled at elaboration
    localparam t_word           UNIT    = WORD_W'(64'd1 << FRAC_BITS);
    localparam longint unsigned STRETCH = ((64'd1001 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam int              DIV_W   = 2 * FRAC_BITS + 1;
    localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(STRETCH << FRAC_BITS);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RELOAD = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0] r_state, n_state;

    // configuration and bucket state
    logic  r_enabled;
    t_word r_max_rate;
    t_word r_max_delay;
    t_word r_fill;
    t_word r_leak_rate;
    t_word r_ceiling;

    // item in flight
    t_op   r_op;
    logic  r_before;
    logic  r_granted;
    t_word r_next;

    // output register
    logic  r_out_valid;
    logic  r_below_limit;
    logic  r_granted_o;
    logic  r_slot_freed;
    t_word r_next_o;
    t_word r_level_o;

    // handshakes; configuration wins when both arrive together
    logic w_in_acc;
    logic w_cfg_acc;
    logic w_cfg_hit;
    logic w_out_free;

    // serial units
    logic             w_mul_start;
    logic             w_mul_busy;
    t_word            w_mul_a;
    t_word            w_mul_b;
    t_word            w_mul_res;
    logic             w_div_start;
    logic             w_div_busy;
    logic [DIV_W-1:0] w_div_quot;

    t_word w_cfg_rate;
    t_word w_cfg_delay;
    t_word w_lim_rate;
    logic  w_room_now;

    // ceiling exceeds level by at least one unit
    function automatic logic f_has_room(t_word ceil_v, t_word fill_v);
        logic [WORD_W:0] diff;
        diff = {1'b0, ceil_v} - {1'b0, fill_v};
        return !diff[WORD_W] && (diff[WORD_W-1:0] >= UNIT);
    endfunction

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_cfg_hit   = w_cfg_acc && (i_cfg_index != CFG_UNUSED);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // register values as they stand after this configuration transaction
    assign w_cfg_rate  = (i_cfg_index == CFG_MAX_RATE)  ? i_cfg_data : r_max_rate;
    assign w_cfg_delay = (i_cfg_index == CFG_MAX_DELAY) ? i_cfg_data : r_max_delay;
    // update limit: new leak rate is the smaller of limit and max rate
    assign w_lim_rate  = (i_limit < r_max_rate) ? i_limit : r_max_rate;

    // the multiplier serves the reload, the leak amount and the new ceiling
    assign w_mul_start = w_cfg_hit ||
                         (w_in_acc && ((i_op == OP_LEAK) || (i_op == OP_UPDATE)));
    always_comb begin
        w_mul_a = w_cfg_rate;
        w_mul_b = w_cfg_delay;
        if (!w_cfg_acc) begin
            if (i_op == OP_LEAK) begin
                w_mul_a = r_leak_rate;
                w_mul_b = i_interval;
            end else begin
                w_mul_a = w_lim_rate;
                w_mul_b = r_max_delay;
            end
        end
    end

    // the divider runs on every leak tick, its quotient used only above one unit
    assign w_div_start = w_in_acc && (i_op == OP_LEAK);

    lbrl_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .o_busy   (w_mul_busy),
        .o_result (w_mul_res)
    );

    lbrl_div #(
        .DW (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (DIVIDEND),
        .i_divisor  (r_leak_rate),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot)
    );

    assign w_room_now = f_has_room(r_ceiling, r_fill);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_cfg_hit) begin
                    n_state = S_RELOAD;
                end else if (w_in_acc) begin
                    n_state = ((i_op == OP_LEAK) || (i_op == OP_UPDATE)) ? S_RUN : S_APPLY;
                end
            end
            S_RELOAD: begin
                if (!w_mul_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                if (!w_mul_busy && !w_div_busy) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enabled   <= 1'b0;
            r_max_rate  <= '0;
            r_max_delay <= '0;
            r_fill      <= '0;
            r_leak_rate <= '0;
            r_ceiling   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration transaction: store and reload the leak rate
            if (w_cfg_hit) begin
                unique case (i_cfg_index)
                    CFG_ENABLED:   r_enabled   <= i_cfg_data[0];
                    CFG_MAX_RATE:  r_max_rate  <= i_cfg_data;
                    CFG_MAX_DELAY: r_max_delay <= i_cfg_data;
                    default:       r_enabled   <= r_enabled;
                endcase
                r_leak_rate <= w_cfg_rate;
            end

            if (w_in_acc && (i_op == OP_UPDATE)) begin
                r_leak_rate <= w_lim_rate;
            end

            if ((r_state == S_RELOAD) && !w_mul_busy) begin
                r_ceiling <= w_mul_res;
            end

            if (r_state == S_APPLY) begin
                case (r_op)
                    OP_BORROW: begin
                        if (r_enabled && r_before) begin
                            r_fill <= r_fill + UNIT;
                        end
                    end
                    OP_LEAK: begin
                        // drain clamps at empty
                        r_fill <= (r_fill > w_mul_res) ? (r_fill - w_mul_res) : '0;
                    end
                    OP_UPDATE: r_ceiling <= w_mul_res;
                    default: r_fill <= r_fill;
                endcase
            end

            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= i_op;
            r_before  <= w_room_now;
            r_granted <= 1'b0;
            r_next    <= '0;
        end else if (r_state == S_APPLY) begin
            if (r_op == OP_BORROW) begin
                r_granted <= !r_enabled || r_before;
            end
            if (r_op == OP_LEAK) begin
                // next tick in 1.001 / rate above one unit, else one second
                r_next <= (r_leak_rate > UNIT) ?
                          {{(WORD_W-FRAC_BITS-1){1'b0}}, w_div_quot[FRAC_BITS:0]} : UNIT;
            end
        end
    end

    // result register, loaded when the previous result has been taken
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && w_out_free) begin
            r_below_limit <= !r_enabled || w_room_now;
            r_granted_o   <= r_granted;
            r_slot_freed  <= (r_op == OP_LEAK) && !r_before && w_room_now;
            r_next_o      <= r_next;
            r_level_o     <= r_fill;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_below_limit   = r_below_limit;
    assign o_granted       = r_granted_o;
    assign o_slot_freed    = r_slot_freed;
    assign o_next_interval = r_next_o;
    assign o_level         = r_level_o;

    // a leak or update transaction always sets the multiplier going
    a_mul_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && ((i_op == OP_LEAK) || (i_op == OP_UPDATE))) |=> w_mul_busy)
        else $error("multiplier not started for leak or update");

    // no serial unit may still be running once the sequencer is idle
    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_mul_busy && !w_div_busy))
        else $error("serial unit busy while idle");

    // the output register fills only from the finishing step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside finishing step");

    // a result never carries both a grant and a freed slot
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_granted && o_slot_freed))
        else $error("granted and slot_freed together");

endmodule
`default_nettype wire
